/* sv/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg
// Types and constants shared by the soft timer table controller, datapath
// and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int SLOT_W      = 4;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_STOP   = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_UPDATE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    K_STARTED = 3'd0,
    K_NOFREE  = 3'd1,
    K_STOPPED = 3'd2,
    K_STATUS  = 3'd3,
    K_FIRED   = 3'd4,
    K_NONE    = 3'd5
  } kind_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] period;
    logic        periodic;
    logic [3:0]  timer_id;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] slot;
    logic       running;
    logic       last;
  } rsp_t;

  // One slot table entry
  typedef struct packed {
    logic        repeats;
    logic [31:0] period;
    logic [31:0] start;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REPLY,
    ST_START,
    ST_UPDATE,
    ST_DRAIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic reply;
    logic start_go;
    logic upd_go;
    logic drain;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic slot_idle;
    logic scan_last;
    logic scan_end;
    logic upd_block;
  } stat_t;

endpackage

`default_nettype wire

/* sv/stt_ctrl.sv */
// ----------------------------------------------------------------------------
// stt_ctrl
// Command sequencer: accepts one transaction, steps the datapath through the
// slot walk or reply, and returns to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire logic [1:0]     req_cmd,
  input  wire stt_pkg::stat_t stat,
  output stt_pkg::ctl_t       ctl
);

  stt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    req_ready  = 1'b0;
    unique case (state)
      stt_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctl.load = 1'b1;
          unique case (req_cmd)
            stt_pkg::CMD_START:  state_next = stt_pkg::ST_START;
            stt_pkg::CMD_UPDATE: state_next = stt_pkg::ST_UPDATE;
            default:             state_next = stt_pkg::ST_REPLY;
          endcase
        end
      end
      stt_pkg::ST_REPLY: begin
        if (stat.out_free) begin
          ctl.reply  = 1'b1;
          state_next = stt_pkg::ST_IDLE;
        end
      end
      stt_pkg::ST_START: begin
        if (stat.out_free) begin
          ctl.start_go = 1'b1;
          if (stat.slot_idle || stat.scan_last) begin
            state_next = stt_pkg::ST_IDLE;
          end
        end
      end
      stt_pkg::ST_UPDATE: begin
        if (stat.scan_end) begin
          state_next = stt_pkg::ST_DRAIN;
        end else if (!stat.upd_block) begin
          ctl.upd_go = 1'b1;
        end
      end
      stt_pkg::ST_DRAIN: begin
        if (stat.out_free) begin
          ctl.drain  = 1'b1;
          state_next = stt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/stt_dp.sv */
// ----------------------------------------------------------------------------
// stt_dp
// Slot table datapath: slot memory, running flags, scan index, fired-slot
// holding register and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_dp #(
  parameter int NUM_TIMERS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire stt_pkg::ctl_t ctl,
  output stt_pkg::stat_t     stat,
  input  wire stt_pkg::req_t req_data,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output stt_pkg::rsp_t      rsp_data
);

  localparam int AW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW  = $clog2(NUM_TIMERS + 1);
  localparam int IDW = (AW > 4) ? AW : 4;

  stt_pkg::req_t item;
  stt_pkg::slot_t mem [NUM_TIMERS];
  stt_pkg::slot_t rd_entry;

  logic [NUM_TIMERS-1:0]   running;
  logic [CW-1:0]           idx;
  logic                    ev_valid;
  logic [AW-1:0]           ev_idx;
  logic                    pend_valid;
  logic [AW-1:0]           pend_slot;
  logic [stt_pkg::CNT_W-1:0] fire_cnt;

  logic [AW-1:0]  cur_idx;
  logic [IDW-1:0] id_ext;
  logic [AW-1:0]  id_idx;
  logic           id_in_range;
  logic           out_free;
  logic           slot_idle;
  logic           scan_last;
  logic           issuing;
  logic [31:0]    elapsed;
  logic           fire;
  logic           report;
  logic           emit;
  stt_pkg::rsp_t  emit_data;
  logic           we;
  logic [AW-1:0]  waddr;
  stt_pkg::slot_t wdata;
  logic           rd_en;

  assign cur_idx     = idx[AW-1:0];
  assign id_ext      = IDW'(item.timer_id);
  assign id_idx      = id_ext[AW-1:0];
  assign id_in_range = 32'(item.timer_id) < NUM_TIMERS;
  assign out_free    = !rsp_valid || rsp_ready;
  assign slot_idle   = !running[cur_idx];
  assign scan_last   = idx == CW'(NUM_TIMERS - 1);
  assign issuing     = idx != CW'(NUM_TIMERS);

  // Modular elapsed time; fire only when strictly past the period
  assign elapsed = item.now - rd_entry.start;
  assign fire    = ev_valid && running[ev_idx] && (elapsed > rd_entry.period);
  assign report  = fire_cnt < stt_pkg::CNT_W'(stt_pkg::MAX_RESULTS);

  assign stat.out_free  = out_free;
  assign stat.slot_idle = slot_idle;
  assign stat.scan_last = scan_last;
  assign stat.scan_end  = !issuing && !ev_valid;
  // Hold the walk while a held fired slot cannot be pushed out
  assign stat.upd_block = fire && report && pend_valid && !out_free;

  assign rd_en = ctl.upd_go && issuing;

  always_comb begin
    emit      = 1'b0;
    emit_data = '0;
    if (ctl.reply) begin
      emit           = 1'b1;
      emit_data.slot = item.timer_id;
      emit_data.last = 1'b1;
      if (item.cmd == stt_pkg::CMD_STOP) begin
        emit_data.kind = stt_pkg::K_STOPPED;
      end else begin
        emit_data.kind    = stt_pkg::K_STATUS;
        emit_data.running = id_in_range && running[id_idx];
      end
    end else if (ctl.start_go) begin
      emit_data.last = 1'b1;
      if (slot_idle) begin
        emit           = 1'b1;
        emit_data.kind = stt_pkg::K_STARTED;
        emit_data.slot = stt_pkg::SLOT_W'(cur_idx);
      end else if (scan_last) begin
        emit           = 1'b1;
        emit_data.kind = stt_pkg::K_NOFREE;
      end
    end else if (ctl.upd_go) begin
      if (fire && report && pend_valid) begin
        emit           = 1'b1;
        emit_data.kind = stt_pkg::K_FIRED;
        emit_data.slot = stt_pkg::SLOT_W'(pend_slot);
      end
    end else if (ctl.drain) begin
      emit           = 1'b1;
      emit_data.last = 1'b1;
      if (pend_valid) begin
        emit_data.kind = stt_pkg::K_FIRED;
        emit_data.slot = stt_pkg::SLOT_W'(pend_slot);
      end else begin
        emit_data.kind = stt_pkg::K_NONE;
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur_idx;
    wdata = '{repeats: item.periodic, period: item.period, start: item.now};
    if (ctl.start_go && slot_idle) begin
      we = 1'b1;
    end else if (ctl.upd_go && fire) begin
      we    = 1'b1;
      waddr = ev_idx;
      wdata = '{repeats: rd_entry.repeats, period: rd_entry.period, start: item.now};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_entry <= mem[cur_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item <= req_data;
    end
    if (ctl.upd_go) begin
      ev_idx <= cur_idx;
      if (fire && report) begin
        pend_slot <= ev_idx;
      end
    end
    if (emit) begin
      rsp_data <= emit_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= '0;
      idx        <= '0;
      ev_valid   <= 1'b0;
      pend_valid <= 1'b0;
      fire_cnt   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (ctl.load) begin
        idx        <= '0;
        ev_valid   <= 1'b0;
        pend_valid <= 1'b0;
        fire_cnt   <= '0;
      end
      if (ctl.reply && item.cmd == stt_pkg::CMD_STOP && id_in_range) begin
        running[id_idx] <= 1'b0;
      end
      if (ctl.start_go) begin
        if (slot_idle) begin
          running[cur_idx] <= 1'b1;
        end else if (!scan_last) begin
          idx <= idx + 1'b1;
        end
      end
      if (ctl.upd_go) begin
        ev_valid <= issuing;
        if (issuing) begin
          idx <= idx + 1'b1;
        end
        if (fire) begin
          // one-shot slots go idle, periodic ones keep running
          running[ev_idx] <= rd_entry.repeats;
          if (report) begin
            pend_valid <= 1'b1;
            fire_cnt   <= fire_cnt + 1'b1;
          end
        end
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/soft_timer_table_unit.sv */
// ----------------------------------------------------------------------------
// soft_timer_table_unit
// Table of NUM_TIMERS software timer slots with start, stop, query and
// update commands.
//
// Requests arrive on req_valid/req_ready/req_data, one transaction at a time;
// responses leave on rsp_valid/rsp_ready/rsp_data, last set on the final
// response of each request. Stop and query answer from the reply state once
// the response register is free. Start walks the running flags one slot a
// cycle from slot zero while the response register is free and answers at
// the first idle slot or with no-free after the last slot. Update reads the
// slot memory one slot a cycle through its registered read port unless a
// fired slot waits to be pushed out, reports at most 16 fired slots in
// index order and ends with a drain response. A fired slot is held until
// the next one or the drain, so that the final one can carry last.
// req_ready is high only in idle. Reset clears all running flags; slot
// contents stay unknown until a start writes them. When the receiver
// stalls, the response register holds its transaction and the slot walk
// waits whenever it has another one to push; a new request is still taken
// while the last response waits.
// ----------------------------------------------------------------------------
`default_nettype none

module soft_timer_table_unit #(
  parameter int NUM_TIMERS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire stt_pkg::req_t req_data,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output stt_pkg::rsp_t      rsp_data
);

  stt_pkg::ctl_t  ctl;
  stt_pkg::stat_t stat;

  stt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_cmd   (req_data.cmd),
    .stat      (stat),
    .ctl       (ctl)
  );

  stt_dp #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for soft_timer_table_unit. Directed tests cover the reset state,
// zero and maximum periods, clock wrap, one-shot and periodic firing, stop,
// query, a full table and all sixteen slots firing at once. Random tests then
// run start/stop/query/update streams over an advancing clock under several
// idle and stall mixes plus a long receiver hold-off. Every response is
// checked in order against a predictor that tracks the slot table.
// ----------------------------------------------------------------------------

module tb;

  localparam int NUM_SLOTS     = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 80;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  stt_pkg::req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  stt_pkg::rsp_t rsp_data;

  // Predicted slot table
  logic [31:0]   tmr_period [NUM_SLOTS];
  logic [31:0]   tmr_start  [NUM_SLOTS];
  logic          tmr_run    [NUM_SLOTS] = '{default: 1'b0};
  logic          tmr_rep    [NUM_SLOTS];
  stt_pkg::rsp_t pending_rsp [$];

  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  int          hold_gen     = 0;
  int          hold_seen    = 0;
  int          hold_left    = 0;
  int          errors       = 0;
  int          n_req        = 0;
  int          n_rsp        = 0;
  int          n_fired      = 0;
  int          quiet_cycles = 0;
  logic [31:0] tick;

  soft_timer_table_unit #(
    .NUM_TIMERS(NUM_SLOTS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one request to the table and queue the responses it produces
  function automatic void predict_timers(input stt_pkg::req_t r);
    stt_pkg::rsp_t e;
    int            i;
    int            k;
    int            hits [$];
    logic [31:0]   elapsed;
    bit            claimed;
    e = '0;
    e.last = 1'b1;
    claimed = 1'b0;
    case (r.cmd)
      stt_pkg::CMD_START: begin
        e.kind = stt_pkg::K_NOFREE;
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (!claimed && !tmr_run[i]) begin
            tmr_period[i] = r.period;
            tmr_rep[i]    = r.periodic;
            tmr_start[i]  = r.now;
            tmr_run[i]    = 1'b1;
            e.kind        = stt_pkg::K_STARTED;
            e.slot        = i[3:0];
            claimed       = 1'b1;
          end
        end
        pending_rsp.push_back(e);
      end
      stt_pkg::CMD_STOP: begin
        tmr_run[r.timer_id] = 1'b0;
        e.kind = stt_pkg::K_STOPPED;
        e.slot = r.timer_id;
        pending_rsp.push_back(e);
      end
      stt_pkg::CMD_QUERY: begin
        e.kind    = stt_pkg::K_STATUS;
        e.slot    = r.timer_id;
        e.running = tmr_run[r.timer_id];
        pending_rsp.push_back(e);
      end
      default: begin
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (tmr_run[i]) begin
            elapsed = r.now - tmr_start[i];
            if (elapsed > tmr_period[i]) begin
              tmr_run[i]   = tmr_rep[i];
              tmr_start[i] = r.now;
              if (hits.size() < stt_pkg::MAX_RESULTS) hits.push_back(i);
            end
          end
        end
        if (hits.size() == 0) begin
          e.kind = stt_pkg::K_NONE;
          pending_rsp.push_back(e);
        end else begin
          for (k = 0; k < hits.size(); k++) begin
            e.kind = stt_pkg::K_FIRED;
            e.slot = hits[k][3:0];
            e.last = (k == hits.size() - 1);
            pending_rsp.push_back(e);
          end
        end
      end
    endcase
  endfunction

  function automatic stt_pkg::req_t noise_item();
    stt_pkg::req_t r;
    r.cmd      = 2'($urandom);
    r.period   = $urandom;
    r.periodic = 1'($urandom);
    r.timer_id = 4'($urandom);
    r.now      = $urandom;
    return r;
  endfunction

  // Mostly well-formed traffic on a rising clock; a few items are pure noise
  function automatic stt_pkg::req_t make_item();
    stt_pkg::req_t r;
    int            pick;
    int            j;
    int            base;
    r = noise_item();
    pick = $urandom_range(0, 99);
    if (pick < 8) return r;
    tick = tick + $urandom_range(0, 12);
    if (pick < 11) tick = tick + $urandom;
    if (pick < 45) begin
      r.cmd    = stt_pkg::CMD_START;
      r.period = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
      r.now    = tick;
    end else if (pick < 72) begin
      r.cmd = (pick < 60) ? stt_pkg::CMD_STOP : stt_pkg::CMD_QUERY;
      // aim at a running slot half the time
      if ($urandom_range(0, 1) == 1) begin
        base = $urandom_range(0, NUM_SLOTS - 1);
        for (j = NUM_SLOTS - 1; j >= 0; j--) begin
          if (tmr_run[(base + j) % NUM_SLOTS]) r.timer_id = 4'((base + j) % NUM_SLOTS);
        end
      end
    end else begin
      r.cmd = stt_pkg::CMD_UPDATE;
      r.now = tick;
    end
    return r;
  endfunction

  task automatic send_request(input stt_pkg::req_t r);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_timers(r);
    n_req++;
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    stt_pkg::req_t r;
    r = noise_item();
    r.cmd = stt_pkg::CMD_QUERY;
    r.timer_id = 4'd15;
    send_request(r);
    r = noise_item();
    r.cmd = stt_pkg::CMD_UPDATE;
    send_request(r);
    // zero period one-shot and maximum period periodic, just before the wrap
    r = noise_item();
    r.cmd = stt_pkg::CMD_START;
    r.period = 32'd0;
    r.periodic = 1'b0;
    r.now = 32'hFFFF_FFFC;
    send_request(r);
    r = noise_item();
    r.cmd = stt_pkg::CMD_START;
    r.period = 32'hFFFF_FFFF;
    r.periodic = 1'b1;
    r.now = 32'hFFFF_FFFC;
    send_request(r);
    // elapsed equal to period must not fire
    r = noise_item();
    r.cmd = stt_pkg::CMD_UPDATE;
    r.now = 32'hFFFF_FFFC;
    send_request(r);
    r = noise_item();
    r.cmd = stt_pkg::CMD_UPDATE;
    r.now = 32'd2;
    send_request(r);
    r = noise_item();
    r.cmd = stt_pkg::CMD_QUERY;
    r.timer_id = 4'd0;
    send_request(r);
    r = noise_item();
    r.cmd = stt_pkg::CMD_STOP;
    r.timer_id = 4'd1;
    send_request(r);
    r = noise_item();
    r.cmd = stt_pkg::CMD_QUERY;
    r.timer_id = 4'd1;
    send_request(r);
  endtask

  task automatic test_table_full();
    stt_pkg::req_t r;
    int            i;
    for (i = 0; i < NUM_SLOTS; i++) begin
      if (!tmr_run[i]) begin
        r = noise_item();
        r.cmd = stt_pkg::CMD_START;
        r.period = $urandom_range(0, 3);
        r.now = 32'd10;
        send_request(r);
      end
    end
    r = noise_item();
    r.cmd = stt_pkg::CMD_START;
    send_request(r);
    // every slot fires in one update
    r = noise_item();
    r.cmd = stt_pkg::CMD_UPDATE;
    r.now = 32'd10 + $urandom_range(4, 100);
    send_request(r);
  endtask

  task automatic test_random(input int tx_pct, input int rx_pct, input int count);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) send_request(make_item());
  endtask

  // Hold the receiver off while requests keep coming until the block stalls
  task automatic test_backpressure();
    tx_idle_pct = 0;
    hold_gen++;
    repeat (16) send_request(make_item());
    wait_for_results();
  endtask

  always @(posedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : check_rsp
    stt_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      n_rsp++;
      if (rsp_data.kind == stt_pkg::K_FIRED) n_fired++;
      if (pending_rsp.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected response kind %0d slot %0d running %0b last %0b",
                   $realtime, rsp_data.kind, rsp_data.slot, rsp_data.running,
                   rsp_data.last);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_data.kind !== want.kind || rsp_data.slot !== want.slot ||
            rsp_data.running !== want.running || rsp_data.last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("%0t: expected kind %0d slot %0d running %0b last %0b, %s %0d %0d %0b %0b",
                     $realtime, want.kind, want.slot, want.running, want.last,
                     "got", rsp_data.kind, rsp_data.slot, rsp_data.running,
                     rsp_data.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("soft_timer_table_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    tick = $urandom;
    tx_idle_pct  = 16;
    rx_stall_pct = 59;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_table_full();
    wait_for_results();
    test_random(16, 59, RANDOM_ITEMS);
    test_backpressure();
    // push the clock across the 32-bit wrap
    tick = 32'hFFFF_FF80;
    test_random(59, 16, RANDOM_ITEMS);
    wait_for_results();
    test_random(0, 0, RANDOM_ITEMS);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d requests (start, stop, query, update) and checked %0d responses,",
             n_req, n_rsp);
    $display("%0d of them timer firings, across full table, clock wrap and stalls.",
             n_fired);
    if (errors == 0) begin
      $display("soft_timer_table_unit: match");
    end else begin
      $display("%0d response errors", errors);
      $display("soft_timer_table_unit: mismatch");
    end
    $finish;
  end

endmodule

/* soft_timer_table_unit.f */
sv/stt_pkg.sv
sv/stt_ctrl.sv
sv/stt_dp.sv
sv/soft_timer_table_unit.sv
sim/tb.sv
